@@ design/dofe_pkg.sv @@
// Shared types, codes and constants of the DMA offload front end.
package dofe_pkg;

	// Item kinds on the input channel.
	localparam logic [1:0] OP_INSTR = 2'd0;
	localparam logic [1:0] OP_READY = 2'd1;
	localparam logic [1:0] OP_DONE  = 2'd2;

	// Instruction opcodes (funct7).
	localparam logic [6:0] F7_SRC      = 7'b0000000;
	localparam logic [6:0] F7_DST      = 7'b0000001;
	localparam logic [6:0] F7_CPY_IMM  = 7'b0000010;
	localparam logic [6:0] F7_CPY      = 7'b0000011;
	localparam logic [6:0] F7_STAT_IMM = 7'b0000100;
	localparam logic [6:0] F7_STAT     = 7'b0000101;
	localparam logic [6:0] F7_STR      = 7'b0000110;
	localparam logic [6:0] F7_REP      = 7'b0000111;

	// Status selectors.
	localparam logic [31:0] STAT_DONE_ID = 32'd0;
	localparam logic [31:0] STAT_NEXT_ID = 32'd1;
	localparam logic [31:0] STAT_BUSY    = 32'd2;
	localparam logic [31:0] STAT_FULL    = 32'd3;

	// Result kinds on the output channel.
	localparam logic [1:0] KIND_RESP  = 2'd0;
	localparam logic [1:0] KIND_PUSH  = 2'd1;
	localparam logic [1:0] KIND_GRANT = 2'd2;
	localparam logic [1:0] KIND_IRQ   = 2'd3;

	localparam int IdStartDefault    = 2;
	localparam int QueueDepthDefault = 4;

	typedef struct packed {
		logic [63:0] src;
		logic [63:0] dst;
		logic [31:0] length;
		logic [31:0] sstride;
		logic [31:0] dstride;
		logic [31:0] reps;
		logic [1:0]  cfg;
	} dma_req_t;

	// One queue entry describes all beats caused by one input item. With pair
	// set, a request push beat goes out first, then the final beat.
	typedef struct packed {
		logic        pair;
		logic [1:0]  kind;
		logic        granted;
		logic [31:0] value;
		logic        busy;
		dma_req_t    req;
	} q_entry_t;

endpackage

@@ design/dofe_ifs.sv @@
// Valid/ready channel interfaces for input items and result beats.
interface dofe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [6:0]  funct7;
	logic [31:0] arg_a;
	logic [31:0] arg_b;
	logic        fifo_can_accept;
	logic        engine_busy;

	modport source (output valid, op, funct7, arg_a, arg_b, fifo_can_accept, engine_busy,
		input ready);
	modport sink (input valid, op, funct7, arg_a, arg_b, fifo_can_accept, engine_busy,
		output ready);
endinterface

interface dofe_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic        granted;
	logic [31:0] result_value;
	logic [63:0] req_src;
	logic [63:0] req_dst;
	logic [31:0] req_length;
	logic [31:0] req_src_stride;
	logic [31:0] req_dst_stride;
	logic [31:0] req_reps;
	logic [1:0]  req_config;
	logic        busy_res;
	logic        last;

	modport source (output valid, kind, granted, result_value, req_src, req_dst, req_length,
		req_src_stride, req_dst_stride, req_reps, req_config, busy_res, last, input ready);
	modport sink (input valid, kind, granted, result_value, req_src, req_dst, req_length,
		req_src_stride, req_dst_stride, req_reps, req_config, busy_res, last, output ready);
endinterface

@@ design/dofe_front.sv @@
// Front part: accepts items, keeps the instruction state and transfer ids, and queues results.
module dofe_front #(
	parameter int IdStart = dofe_pkg::IdStartDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	dofe_in_if.sink            item,
	input  logic               q_full,
	output logic               q_push,
	output dofe_pkg::q_entry_t q_entry
);
	import dofe_pkg::*;

	localparam logic [31:0] IdFirst = 32'(IdStart);

	logic [63:0] src_q, src_d;
	logic [63:0] dst_q, dst_d;
	logic [31:0] sstride_q, sstride_d;
	logic [31:0] dstride_q, dstride_d;
	logic [31:0] reps_q, reps_d;
	logic [31:0] next_id_q, next_id_d;
	logic [31:0] done_id_q, done_id_d;
	logic        stall_q, stall_d;
	logic        replay_q, replay_d;
	dma_req_t    stall_req_q;
	logic [31:0] stall_tid_q;
	logic [31:0] replay_id_q;
	logic        stall_load;
	logic        replay_load;
	logic        acc;
	dma_req_t    new_req;

	function automatic logic [31:0] bump_id(input logic [31:0] v);
		logic [31:0] n;
		n = v + 32'd1;
		if (n < IdFirst) n = IdFirst;
		return n;
	endfunction

	assign item.ready = !q_full;
	assign acc = item.valid && !q_full;

	always_comb begin
		new_req.src     = src_q;
		new_req.dst     = dst_q;
		new_req.length  = item.arg_a;
		new_req.sstride = sstride_q;
		new_req.dstride = dstride_q;
		new_req.reps    = reps_q;
		new_req.cfg     = item.arg_b[1:0];
	end

	always_comb begin
		src_d       = src_q;
		dst_d       = dst_q;
		sstride_d   = sstride_q;
		dstride_d   = dstride_q;
		reps_d      = reps_q;
		next_id_d   = next_id_q;
		done_id_d   = done_id_q;
		stall_d     = stall_q;
		replay_d    = replay_q;
		stall_load  = 1'b0;
		replay_load = 1'b0;
		q_push      = 1'b0;
		q_entry     = '0;
		if (acc) begin
			case (item.op)
				OP_INSTR: begin
					q_push          = 1'b1;
					q_entry.kind    = KIND_RESP;
					q_entry.granted = 1'b1;
					case (item.funct7)
						F7_SRC: src_d = {item.arg_b, item.arg_a};
						F7_DST: dst_d = {item.arg_b, item.arg_a};
						F7_STR: begin
							sstride_d = item.arg_a;
							dstride_d = item.arg_b;
						end
						F7_REP: reps_d = item.arg_a;
						F7_CPY, F7_CPY_IMM: begin
							if (stall_q) begin
								q_entry.granted = 1'b0;
								q_entry.value   = stall_tid_q;
							end else if (replay_q) begin
								replay_d      = 1'b0;
								q_entry.value = replay_id_q;
							end else begin
								q_entry.value = next_id_q;
								next_id_d     = bump_id(next_id_q);
								if (item.fifo_can_accept) begin
									q_entry.pair = 1'b1;
									q_entry.req  = new_req;
								end else begin
									stall_d         = 1'b1;
									stall_load      = 1'b1;
									q_entry.granted = 1'b0;
								end
							end
						end
						F7_STAT, F7_STAT_IMM: begin
							case (item.arg_b)
								STAT_DONE_ID: q_entry.value = done_id_q;
								STAT_NEXT_ID: q_entry.value = next_id_q + 32'd1;
								STAT_BUSY:    q_entry.value =
									{31'd0, (next_id_q - done_id_q) != 32'd1};
								STAT_FULL:    q_entry.value = {31'd0, !item.fifo_can_accept};
								default:      q_entry.value = '0;
							endcase
						end
						default: ;
					endcase
					q_entry.busy = item.engine_busy || stall_d;
				end
				OP_READY: begin
					if (stall_q && item.fifo_can_accept) begin
						stall_d       = 1'b0;
						replay_d      = 1'b1;
						replay_load   = 1'b1;
						q_push        = 1'b1;
						q_entry.pair  = 1'b1;
						q_entry.kind  = KIND_GRANT;
						q_entry.value = stall_tid_q;
						q_entry.req   = stall_req_q;
						q_entry.busy  = item.engine_busy;
					end
				end
				OP_DONE: begin
					done_id_d    = bump_id(done_id_q);
					q_push       = 1'b1;
					q_entry.kind = KIND_IRQ;
					q_entry.busy = item.engine_busy || stall_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q     <= '0;
			dst_q     <= '0;
			sstride_q <= '0;
			dstride_q <= '0;
			reps_q    <= '0;
			next_id_q <= IdFirst;
			done_id_q <= IdFirst - 32'd1;
			stall_q   <= 1'b0;
			replay_q  <= 1'b0;
		end else begin
			src_q     <= src_d;
			dst_q     <= dst_d;
			sstride_q <= sstride_d;
			dstride_q <= dstride_d;
			reps_q    <= reps_d;
			next_id_q <= next_id_d;
			done_id_q <= done_id_d;
			stall_q   <= stall_d;
			replay_q  <= replay_d;
		end
	end

	always_ff @(posedge clk) begin
		if (stall_load) begin
			stall_req_q <= new_req;
			stall_tid_q <= next_id_q;
		end
		if (replay_load) replay_id_q <= stall_tid_q;
	end

endmodule

@@ design/dofe_queue.sv @@
// Short queue of result entries between the front and back parts.
module dofe_queue #(
	parameter int Depth = dofe_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dofe_pkg::q_entry_t push_entry,
	input  logic               pop,
	output dofe_pkg::q_entry_t head,
	output logic               full,
	output logic               empty
);
	import dofe_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

	q_entry_t        mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CntW'(Depth));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
			if (do_push && !do_pop) count_q <= count_q + CntW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

@@ design/dofe_back.sv @@
// Back part: turns each queued entry into one or two result beats.
module dofe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dofe_pkg::q_entry_t head,
	input  logic               empty,
	output logic               pop,
	dofe_out_if.source         result
);
	import dofe_pkg::*;

	logic beat_q;
	logic first_of_pair;
	logic acc;

	// The push beat of a pair goes out before the final beat.
	assign first_of_pair = head.pair && !beat_q;
	assign acc           = result.valid && result.ready;
	assign pop           = acc && !first_of_pair;

	always_comb begin
		result.valid        = !empty;
		result.kind         = first_of_pair ? KIND_PUSH : head.kind;
		result.granted      = first_of_pair ? 1'b0 : head.granted;
		result.result_value = head.value;
		result.busy_res     = head.busy;
		result.last         = !first_of_pair;
		if (first_of_pair) begin
			result.req_src        = head.req.src;
			result.req_dst        = head.req.dst;
			result.req_length     = head.req.length;
			result.req_src_stride = head.req.sstride;
			result.req_dst_stride = head.req.dstride;
			result.req_reps       = head.req.reps;
			result.req_config     = head.req.cfg;
		end else begin
			result.req_src        = '0;
			result.req_dst        = '0;
			result.req_length     = '0;
			result.req_src_stride = '0;
			result.req_dst_stride = '0;
			result.req_reps       = '0;
			result.req_config     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= 1'b0;
		end else if (acc) begin
			beat_q <= first_of_pair;
		end
	end

endmodule

@@ design/dma_offload_frontend.sv @@
// Top level of the DMA offload front end: front part, result queue and back part.
// Usage:
// The item channel takes one beat per offloaded core instruction, request-FIFO-ready
// event or transfer-done event. The result channel returns, per item, zero, one or
// two beats; the last beat of an item has last set. A copy that pushes a request and
// a ready event that releases a stalled request give a push beat and then a response
// or grant notice; a done event gives one interrupt beat.
// The front part takes one item every cycle while the result queue has room; its
// state updates complete in the accept cycle. An item's first beat is offered once
// its entry reaches the queue head. The back part sends one beat per cycle while the
// receiver is ready, so an item with two beats holds the result channel for both in
// turn, and sustained throughput is set by the single result port.
// When the receiver stalls, beats wait at the queue head and the queue (QueueDepth
// entries) keeps absorbing items; item.ready falls only when it is full.
// Reset clears the address, stride and repeat registers, sets the next id to IdStart
// and the completed id to IdStart minus one, drops any stalled request and empties
// the queue. No clearing pass is needed; items are taken right after reset.
module dma_offload_frontend #(
	parameter int IdStart    = dofe_pkg::IdStartDefault,
	parameter int QueueDepth = dofe_pkg::QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	dofe_in_if.sink    item,
	dofe_out_if.source result
);
	import dofe_pkg::*;

	q_entry_t push_entry;
	q_entry_t head;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;

	dofe_front #(
		.IdStart (IdStart)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (push_entry)
	);

	dofe_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	dofe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (q_pop),
		.result (result)
	);

endmodule

@@ sim/tb_dma_offload_frontend.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the DMA offload front end: directed table, then random items.
module tb_dma_offload_frontend;
	import dofe_pkg::*;

	localparam int ID_START     = IdStartDefault;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 425;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_LIMIT  = 50;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [6:0] F7_UNUSED = 7'h7F;
	localparam logic [6:0] F7_GAP    = 7'h08;

	typedef struct packed {
		logic [1:0]  op;
		logic [6:0]  funct7;
		logic [31:0] arg_a;
		logic [31:0] arg_b;
		logic        can;
		logic        ebusy;
	} stim_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        granted;
		logic [31:0] value;
		dma_req_t    req;
		logic        busy;
		logic        last;
	} beat_t;

	typedef struct packed {
		logic [1:0] count;
		beat_t      head;
		beat_t      tail;
	} outcome_t;

	// A row of the directed table; typed rows carry the response read off by hand.
	typedef struct packed {
		stim_t       s;
		logic        typed;
		logic        granted;
		logic [31:0] value;
	} row_t;

	logic clk;
	logic arst_n;

	dofe_in_if  item_ch();
	dofe_out_if result_ch();

	dma_offload_frontend i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Mirror of the front end state.
	logic [63:0] src_addr;
	logic [63:0] dst_addr;
	logic [31:0] src_pitch;
	logic [31:0] dst_pitch;
	logic [31:0] rep_count;
	logic [31:0] next_id;
	logic [31:0] done_id;
	logic        stall_pending;
	dma_req_t    stall_req;
	logic [31:0] stall_id;
	logic        replay_pending;
	logic [31:0] replay_id;

	beat_t pending_beats[$];
	row_t  plan[$];
	int    mismatches = 0;
	int    cycles = 0;
	bit    steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [31:0] bump_id(input logic [31:0] v);
		logic [31:0] n;
		n = v + 32'd1;
		if (n < 32'(ID_START))
			n = 32'(ID_START);
		return n;
	endfunction

	function automatic beat_t make_beat(input logic [1:0] kind, input logic granted,
			input logic [31:0] value, input dma_req_t req, input logic busy, input logic last);
		beat_t b;
		b.kind    = kind;
		b.granted = granted;
		b.value   = value;
		b.req     = req;
		b.busy    = busy;
		b.last    = last;
		return b;
	endfunction

	// Applies one item to the mirrored state and returns the beats it causes.
	function automatic outcome_t next_beats(input stim_t s);
		outcome_t    o;
		dma_req_t    r;
		logic [31:0] val;
		logic        gr;
		logic        push;
		logic        busy;
		o    = '0;
		r    = '0;
		val  = '0;
		gr   = 1'b1;
		push = 1'b0;
		case (s.op)
			OP_INSTR: begin
				case (s.funct7)
					F7_SRC: src_addr = {s.arg_b, s.arg_a};
					F7_DST: dst_addr = {s.arg_b, s.arg_a};
					F7_STR: begin
						src_pitch = s.arg_a;
						dst_pitch = s.arg_b;
					end
					F7_REP: rep_count = s.arg_a;
					F7_CPY, F7_CPY_IMM: begin
						if (stall_pending) begin
							gr  = 1'b0;
							val = stall_id;
						end else if (replay_pending) begin
							replay_pending = 1'b0;
							val = replay_id;
						end else begin
							val       = next_id;
							next_id   = bump_id(next_id);
							r.src     = src_addr;
							r.dst     = dst_addr;
							r.length  = s.arg_a;
							r.sstride = src_pitch;
							r.dstride = dst_pitch;
							r.reps    = rep_count;
							r.cfg     = s.arg_b[1:0];
							if (s.can) begin
								push = 1'b1;
							end else begin
								stall_pending = 1'b1;
								stall_req     = r;
								stall_id      = val;
								gr            = 1'b0;
							end
						end
					end
					F7_STAT, F7_STAT_IMM: begin
						case (s.arg_b)
							STAT_DONE_ID: val = done_id;
							STAT_NEXT_ID: val = next_id + 32'd1;
							STAT_BUSY:    val = {31'd0, (next_id - done_id) != 32'd1};
							STAT_FULL:    val = {31'd0, !s.can};
							default:      val = '0;
						endcase
					end
					default: ;
				endcase
				busy = s.ebusy | stall_pending;
				o.count = push ? 2'd2 : 2'd1;
				o.head  = make_beat(KIND_PUSH, 1'b0, val, r, busy, 1'b0);
				o.tail  = make_beat(KIND_RESP, gr, val, '0, busy, 1'b1);
			end
			OP_READY: begin
				if (stall_pending && s.can) begin
					stall_pending  = 1'b0;
					replay_pending = 1'b1;
					replay_id      = stall_id;
					o.count = 2'd2;
					o.head  = make_beat(KIND_PUSH, 1'b0, stall_id, stall_req, s.ebusy, 1'b0);
					o.tail  = make_beat(KIND_GRANT, 1'b0, stall_id, '0, s.ebusy, 1'b1);
				end
			end
			OP_DONE: begin
				done_id = bump_id(done_id);
				o.count = 2'd1;
				o.tail  = make_beat(KIND_IRQ, 1'b0, '0, '0, s.ebusy | stall_pending, 1'b1);
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(name, got, want);
	endtask

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready = steady || ($urandom_range(0, 99) >= 16);
		end
	end

	always @(posedge clk) begin : result_monitor
		beat_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_beats.size() == 0) begin
				report_mismatch("beat with nothing expected, kind", 64'(result_ch.kind), '0);
			end else begin
				want = pending_beats.pop_front();
				check_field("kind", 64'(result_ch.kind), 64'(want.kind));
				check_field("granted", 64'(result_ch.granted), 64'(want.granted));
				check_field("result_value", 64'(result_ch.result_value), 64'(want.value));
				check_field("req_src", result_ch.req_src, want.req.src);
				check_field("req_dst", result_ch.req_dst, want.req.dst);
				check_field("req_length", 64'(result_ch.req_length), 64'(want.req.length));
				check_field("req_src_stride", 64'(result_ch.req_src_stride),
					64'(want.req.sstride));
				check_field("req_dst_stride", 64'(result_ch.req_dst_stride),
					64'(want.req.dstride));
				check_field("req_reps", 64'(result_ch.req_reps), 64'(want.req.reps));
				check_field("req_config", 64'(result_ch.req_config), 64'(want.req.cfg));
				check_field("busy_res", 64'(result_ch.busy_res), 64'(want.busy));
				check_field("last", 64'(result_ch.last), 64'(want.last));
			end
		end
	end

	function automatic row_t plan_row(input logic [1:0] op, input logic [6:0] f7,
			input logic [31:0] a, input logic [31:0] b, input logic can, input logic ebusy,
			input logic typed, input logic granted, input logic [31:0] value);
		row_t r;
		r.s.op     = op;
		r.s.funct7 = f7;
		r.s.arg_a  = a;
		r.s.arg_b  = b;
		r.s.can    = can;
		r.s.ebusy  = ebusy;
		r.typed    = typed;
		r.granted  = granted;
		r.value    = value;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic stim_t random_item();
		stim_t s;
		int    pick;
		s.op     = OP_INSTR;
		s.funct7 = F7_SRC;
		s.arg_a  = rand_word();
		s.arg_b  = rand_word();
		s.can    = ($urandom_range(0, 99) < 70);
		s.ebusy  = ($urandom_range(0, 99) < 30);
		pick     = $urandom_range(0, 99);
		if (pick < 10) begin
			s.funct7 = $urandom_range(0, 1) ? F7_SRC : F7_DST;
		end else if (pick < 16) begin
			s.funct7 = F7_STR;
		end else if (pick < 20) begin
			s.funct7 = F7_REP;
		end else if (pick < 45) begin
			s.funct7 = $urandom_range(0, 1) ? F7_CPY : F7_CPY_IMM;
		end else if (pick < 60) begin
			s.op  = OP_READY;
			s.can = ($urandom_range(0, 99) < 80);
		end else if (pick < 72) begin
			s.op = OP_DONE;
		end else if (pick < 88) begin
			s.funct7 = $urandom_range(0, 1) ? F7_STAT : F7_STAT_IMM;
			s.arg_b  = ($urandom_range(0, 7) == 0) ? rand_word() : 32'($urandom_range(0, 3));
		end else begin
			// Noise: any op and any opcode.
			s.op     = 2'($urandom_range(0, 3));
			s.funct7 = 7'($urandom_range(0, 127));
		end
		return s;
	endfunction

	// Called at a falling edge; returns at a falling edge after the beat was taken.
	task automatic drive_item(input stim_t s, input logic typed, input logic granted,
			input logic [31:0] value);
		outcome_t o;
		while (!steady && $urandom_range(0, 99) < 16)
			@(negedge clk);
		item_ch.valid           = 1'b1;
		item_ch.op              = s.op;
		item_ch.funct7          = s.funct7;
		item_ch.arg_a           = s.arg_a;
		item_ch.arg_b           = s.arg_b;
		item_ch.fifo_can_accept = s.can;
		item_ch.engine_busy     = s.ebusy;
		do @(posedge clk); while (!item_ch.ready);
		o = next_beats(s);
		if (typed) begin
			o.tail.granted = granted;
			o.tail.value   = value;
		end
		if (o.count == 2'd2)
			pending_beats.push_back(o.head);
		if (o.count != 2'd0)
			pending_beats.push_back(o.tail);
		@(negedge clk);
		item_ch.valid = 1'b0;
	endtask

	task automatic await_idle();
		while (pending_beats.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		row_t  r;
		stim_t s;
		int    k;
		item_ch.valid           = 1'b0;
		item_ch.op              = OP_INSTR;
		item_ch.funct7          = F7_SRC;
		item_ch.arg_a           = '0;
		item_ch.arg_b           = '0;
		item_ch.fifo_can_accept = 1'b0;
		item_ch.engine_busy     = 1'b0;

		src_addr       = '0;
		dst_addr       = '0;
		src_pitch      = '0;
		dst_pitch      = '0;
		rep_count      = '0;
		next_id        = 32'(ID_START);
		done_id        = 32'(ID_START) - 32'd1;
		stall_pending  = 1'b0;
		stall_req      = '0;
		stall_id       = '0;
		replay_pending = 1'b0;
		replay_id      = '0;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Status words right after reset, then unknown opcodes and extreme setters.
		plan.push_back(plan_row(OP_INSTR, F7_STAT, '0, STAT_DONE_ID, 1, 0,
			1, 1, 32'(ID_START) - 32'd1));
		plan.push_back(plan_row(OP_INSTR, F7_STAT_IMM, '1, STAT_NEXT_ID, 1, 1,
			1, 1, 32'(ID_START) + 32'd1));
		plan.push_back(plan_row(OP_INSTR, F7_STAT, '0, STAT_BUSY, 1, 0, 1, 1, '0));
		plan.push_back(plan_row(OP_INSTR, F7_STAT_IMM, '0, STAT_FULL, 0, 0, 1, 1, 32'd1));
		plan.push_back(plan_row(OP_INSTR, F7_STAT, '0, '1, 1, 0, 1, 1, '0));
		plan.push_back(plan_row(OP_INSTR, F7_UNUSED, '1, '1, 1, 1, 1, 1, '0));
		plan.push_back(plan_row(OP_INSTR, F7_GAP, '0, '0, 0, 0, 1, 1, '0));
		plan.push_back(plan_row(OP_INSTR, F7_SRC, '1, '1, 1, 0, 1, 1, '0));
		plan.push_back(plan_row(OP_INSTR, F7_DST, '0, '0, 1, 1, 1, 1, '0));
		plan.push_back(plan_row(OP_INSTR, F7_STR, '1, 32'h8000_0001, 1, 0, 1, 1, '0));
		plan.push_back(plan_row(OP_INSTR, F7_REP, '1, '0, 1, 0, 1, 1, '0));
		// A pushed copy, then one that stalls, then a copy against the stalled one.
		plan.push_back(plan_row(OP_INSTR, F7_CPY, '1, '1, 1, 0, 1, 1, 32'(ID_START)));
		plan.push_back(plan_row(OP_INSTR, F7_CPY_IMM, '0, '0, 0, 0,
			1, 0, 32'(ID_START) + 32'd1));
		plan.push_back(plan_row(OP_INSTR, F7_CPY, 32'd5, 32'd1, 1, 0,
			1, 0, 32'(ID_START) + 32'd1));
		plan.push_back(plan_row(OP_INSTR, F7_STAT, '0, STAT_FULL, 0, 1, 1, 1, 32'd1));
		plan.push_back(plan_row(OP_INSTR, F7_STAT_IMM, '0, STAT_BUSY, 1, 0, 0, 0, '0));
		// Ready while still full does nothing; the next one releases the request.
		plan.push_back(plan_row(OP_READY, F7_SRC, '0, '0, 0, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_READY, F7_SRC, '0, '0, 1, 1, 0, 0, '0));
		plan.push_back(plan_row(OP_READY, F7_SRC, '0, '0, 1, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_INSTR, F7_CPY_IMM, '0, '0, 0, 0,
			1, 1, 32'(ID_START) + 32'd1));
		plan.push_back(plan_row(OP_INSTR, F7_CPY, 32'h40, 32'd2, 1, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_DONE, F7_SRC, '0, '0, 1, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_DONE, F7_UNUSED, '1, '1, 0, 1, 0, 0, '0));
		plan.push_back(plan_row(OP_UNUSED, F7_UNUSED, '1, '1, 1, 1, 0, 0, '0));
		plan.push_back(plan_row(OP_INSTR, F7_STAT, '0, STAT_DONE_ID, 1, 0, 0, 0, '0));

		foreach (plan[i]) begin
			r = plan[i];
			drive_item(r.s, r.typed, r.granted, r.value);
		end
		await_idle();

		k = 0;
		while (k < RANDOM_ITEMS) begin
			steady = (k >= 200 && k < 300);
			// Hold the sender back until the result side has fully drained.
			if (k == 120)
				await_idle();
			s = random_item();
			drive_item(s, 1'b0, 1'b0, '0);
			k++;
		end
		steady = 1'b0;

		await_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
